// File: sv/assert_macros.svh
// Assertion macros shared by the pick core RTL.
// Include with the bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// File: sv/rbp_pkg.sv
// Shared types and constants of the ray box pick core.
// No dependencies.
package rbp_pkg;
  localparam int MaxBoxes = 16;
  localparam int SlotW = $clog2(MaxBoxes);
  localparam int CountW = $clog2(MaxBoxes + 1);
  // Numerator (34-bit difference shifted by 16) is 50 bits; quotient fits in 50 bits signed.
  localparam int NumW = 50;
  localparam int QuotW = 50;
  localparam logic [30:0] DistSat = 31'h7FFF_FFFF;

  localparam logic [0:0] CmdLoad = 1'b0;
  localparam logic [0:0] CmdQuery = 1'b1;

  localparam logic [0:0] RegBoxCount = 1'b0;
  localparam logic [0:0] RegEpsilon = 1'b1;

  // Commands from controller to datapath.
  typedef struct packed {
    logic start_query;
    logic load_box;
    logic [SlotW-1:0] slot;
    logic [1:0] axis;
    logic setup_axis;
    logic kill_box;
    logic div_start;
    logic div_sel_hi;
    logic take_t0;
    logic take_t1;
    logic box_begin;
    logic box_finish;
  } rbp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic parallel;
    logic slab_out;
    logic div_done;
    logic dead;
  } rbp_stat_t;
endpackage

// File: sv/rbp_div.sv
// Radix-2 restoring signed divider, one quotient bit a cycle, truncating.
// Depends on rbp_pkg.
module rbp_div (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic signed [rbp_pkg::NumW-1:0] num_i,
  input  logic signed [31:0] den_i,
  output logic done_o,
  output logic signed [rbp_pkg::QuotW-1:0] quo_o
);
  localparam int CntW = $clog2(rbp_pkg::NumW + 1);
  logic [rbp_pkg::NumW-1:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q;
  logic neg_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [33:0] trial;

  // Shift one numerator bit into the partial remainder.
  always_comb begin
    trial = {rem_q, quo_q[rbp_pkg::NumW-1]} - {2'b00, den_q};
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      if (!trial[33]) begin
        rem_d = trial[32:0];
        quo_d = {quo_q[rbp_pkg::NumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], quo_q[rbp_pkg::NumW-1]};
        quo_d = {quo_q[rbp_pkg::NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= done_d;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= CntW'(rbp_pkg::NumW);
      end else begin
        busy_q <= busy_d;
        cnt_q <= cnt_d;
      end
    end
  end

  // Load magnitudes on start, else iterate.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i[rbp_pkg::NumW-1] ? -num_i : num_i;
      den_q <= den_i[31] ? -den_i : den_i;
      neg_q <= num_i[rbp_pkg::NumW-1] ^ den_i[31];
      rem_q <= '0;
    end else begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

// File: sv/rbp_datapath.sv
// Box tables, slab bounds, divider and nearest-hit tracking.
// Depends on rbp_pkg, rbp_div and assert_macros.svh.
`include "assert_macros.svh"
module rbp_datapath (
  input  logic clk_i,
  input  logic rst_ni,
  input  rbp_pkg::rbp_cmd_t cmd_i,
  output rbp_pkg::rbp_stat_t stat_o,
  input  logic [15:0] eps_i,
  input  logic signed [31:0] p_x_i, p_y_i, p_z_i, q_x_i, q_y_i, q_z_i,
  output logic hit_o,
  output logic [rbp_pkg::SlotW-1:0] hit_slot_o,
  output logic [30:0] hit_distance_o
);
  localparam int TW = rbp_pkg::QuotW;
  logic signed [31:0] cen_mem [3][rbp_pkg::MaxBoxes];
  logic signed [31:0] half_mem [3][rbp_pkg::MaxBoxes];
  logic signed [31:0] org_q [3];
  logic signed [31:0] dir_q [3];
  logic signed [31:0] cen_q, half_q;
  logic signed [32:0] lo_q, hi_q;
  logic signed [31:0] d_cur;
  logic signed [31:0] o_cur;
  logic [31:0] mag;
  logic signed [TW-1:0] t0_q, tlo_q, thi_q;
  logic thi_inf_q, dead_q;
  logic found_q;
  logic [rbp_pkg::SlotW-1:0] best_slot_q;
  logic signed [TW-1:0] best_t_q;
  logic signed [rbp_pkg::NumW-1:0] num;
  logic signed [TW-1:0] quo, tmin, tmax;
  logic div_done;

  // Write a load word into the tables; latch the query ray and the slab bounds.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_box) begin
      cen_mem[0][cmd_i.slot] <= p_x_i;
      cen_mem[1][cmd_i.slot] <= p_y_i;
      cen_mem[2][cmd_i.slot] <= p_z_i;
      half_mem[0][cmd_i.slot] <= q_x_i;
      half_mem[1][cmd_i.slot] <= q_y_i;
      half_mem[2][cmd_i.slot] <= q_z_i;
    end
    if (cmd_i.start_query) begin
      org_q[0] <= p_x_i;
      org_q[1] <= p_y_i;
      org_q[2] <= p_z_i;
      dir_q[0] <= q_x_i;
      dir_q[1] <= q_y_i;
      dir_q[2] <= q_z_i;
    end
    // Registered table read for the current box and axis.
    cen_q <= cen_mem[cmd_i.axis][cmd_i.slot];
    half_q <= half_mem[cmd_i.axis][cmd_i.slot];
    if (cmd_i.setup_axis) begin
      lo_q <= 33'(cen_q) - 33'(half_q);
      hi_q <= 33'(cen_q) + 33'(half_q);
    end
  end

  assign d_cur = dir_q[cmd_i.axis];
  assign o_cur = org_q[cmd_i.axis];
  assign mag = d_cur[31] ? 32'(-d_cur) : 32'(d_cur);
  assign stat_o.parallel = (d_cur == 32'sd0) || (mag < {16'd0, eps_i});
  assign stat_o.slab_out = (34'(o_cur) < 34'(lo_q)) || (34'(o_cur) > 34'(hi_q));
  assign stat_o.div_done = div_done;
  assign stat_o.dead = dead_q;

  assign num = (cmd_i.div_sel_hi ? (rbp_pkg::NumW'(hi_q) - rbp_pkg::NumW'(o_cur))
                                 : (rbp_pkg::NumW'(lo_q) - rbp_pkg::NumW'(o_cur))) <<< 16;

  rbp_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(cmd_i.div_start),
    .num_i(num), .den_i(d_cur), .done_o(div_done), .quo_o(quo)
  );

  assign tmin = (t0_q > quo) ? quo : t0_q;
  assign tmax = (t0_q > quo) ? t0_q : quo;

  // Narrow the slab interval and track the best box.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      dead_q <= 1'b0;
      thi_inf_q <= 1'b1;
    end else begin
      if (cmd_i.start_query) found_q <= 1'b0;
      if (cmd_i.box_begin) begin
        dead_q <= 1'b0;
        thi_inf_q <= 1'b1;
      end else if (cmd_i.kill_box) begin
        dead_q <= 1'b1;
      end else if (cmd_i.take_t1) begin
        thi_inf_q <= 1'b0;
        if ((tmin > tlo_q ? tmin : tlo_q) > ((!thi_inf_q && thi_q < tmax) ? thi_q : tmax))
          dead_q <= 1'b1;
      end
      if (cmd_i.box_finish && !dead_q && (thi_inf_q || !thi_q[TW-1])
          && (!found_q || tlo_q < best_t_q)) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.box_begin) tlo_q <= '0;
    if (cmd_i.take_t0) t0_q <= quo;
    if (cmd_i.take_t1) begin
      if (tmin > tlo_q) tlo_q <= tmin;
      if (thi_inf_q || tmax < thi_q) thi_q <= tmax;
    end
    if (cmd_i.box_finish && !dead_q && (thi_inf_q || !thi_q[TW-1])
        && (!found_q || tlo_q < best_t_q)) begin
      best_t_q <= tlo_q;
      best_slot_q <= cmd_i.slot;
    end
  end

  assign hit_o = found_q;
  assign hit_slot_o = found_q ? best_slot_q : '0;
  assign hit_distance_o = !found_q ? rbp_pkg::DistSat :
      (best_t_q > TW'(rbp_pkg::DistSat) ? rbp_pkg::DistSat : best_t_q[30:0]);

  `ASSERT_NEXT(a_found_sticky, clk_i, rst_ni, found_q && !cmd_i.start_query, found_q)
  `ASSERT_IMPLY(a_tlo_nonneg, clk_i, rst_ni, found_q, !best_t_q[TW-1])
  `ASSERT_NEXT(a_begin_clears, clk_i, rst_ni, cmd_i.box_begin, !dead_q && thi_inf_q)
endmodule

// File: sv/rbp_ctrl.sv
// Sequencer: loads, per-box per-axis slab steps, and result handshake.
// Depends on rbp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rbp_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic cmd_i,
  input  logic [rbp_pkg::SlotW-1:0] box_slot_i,
  input  logic [rbp_pkg::CountW-1:0] count_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rbp_pkg::rbp_cmd_t cmd_o,
  input  rbp_pkg::rbp_stat_t stat_i
);
  localparam logic [2:0] StIdle = 3'd0, StRead = 3'd1, StSetup = 3'd2, StDiv0 = 3'd3,
                         StWait0 = 3'd4, StDiv1 = 3'd5, StWait1 = 3'd6, StNext = 3'd7;
  logic [2:0] st_q, st_d;
  logic [rbp_pkg::SlotW-1:0] box_q, box_d;
  logic [1:0] ax_q, ax_d;
  logic [rbp_pkg::CountW-1:0] n_q, n_d;
  logic out_q, out_d;
  logic acc;
  logic last_box;

  assign in_stall_o = (st_q != StIdle) || out_q;
  assign acc = in_valid_i && !in_stall_o;
  assign last_box = (rbp_pkg::CountW'(box_q) + 1'b1) >= n_q;

  always_comb begin
    st_d = st_q;
    box_d = box_q;
    ax_d = ax_q;
    n_d = n_q;
    out_d = out_q && out_stall_i;
    cmd_o = '0;
    cmd_o.slot = box_q;
    cmd_o.axis = ax_q;
    case (st_q)
      StIdle: begin
        cmd_o.slot = box_slot_i;
        if (acc && cmd_i == rbp_pkg::CmdLoad) begin
          cmd_o.load_box = 1'b1;
        end else if (acc) begin
          cmd_o.start_query = 1'b1;
          n_d = (count_i > rbp_pkg::CountW'(rbp_pkg::MaxBoxes))
                ? rbp_pkg::CountW'(rbp_pkg::MaxBoxes) : count_i;
          box_d = '0;
          ax_d = '0;
          if (n_d == '0) out_d = 1'b1;
          else st_d = StRead;
        end
      end
      StRead: begin
        if (ax_q == 2'd0) cmd_o.box_begin = 1'b1;
        st_d = StSetup;
      end
      StSetup: begin
        cmd_o.setup_axis = 1'b1;
        st_d = StDiv0;
      end
      // Bounds are ready here: reject a parallel axis whose origin is outside.
      StDiv0: begin
        if (stat_i.dead || stat_i.parallel) begin
          if (stat_i.parallel && stat_i.slab_out) cmd_o.kill_box = 1'b1;
          st_d = StNext;
        end else begin
          cmd_o.div_start = 1'b1;
          st_d = StWait0;
        end
      end
      StWait0: if (stat_i.div_done) begin
        cmd_o.take_t0 = 1'b1;
        st_d = StDiv1;
      end
      StDiv1: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel_hi = 1'b1;
        st_d = StWait1;
      end
      StWait1: begin
        cmd_o.div_sel_hi = 1'b1;
        if (stat_i.div_done) begin
          cmd_o.take_t1 = 1'b1;
          st_d = StNext;
        end
      end
      StNext: begin
        if (ax_q == 2'd2 || stat_i.dead) begin
          cmd_o.box_finish = 1'b1;
          ax_d = '0;
          if (last_box) begin
            st_d = StIdle;
            out_d = 1'b1;
          end else begin
            box_d = box_q + 1'b1;
            st_d = StRead;
          end
        end else begin
          ax_d = ax_q + 1'b1;
          st_d = StRead;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      box_q <= '0;
      ax_q <= '0;
      n_q <= '0;
      out_q <= 1'b0;
    end else begin
      st_q <= st_d;
      box_q <= box_d;
      ax_q <= ax_d;
      n_q <= n_d;
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_q;

  `ASSERT_IMPLY(a_no_accept_busy, clk_i, rst_ni, st_q != StIdle, in_stall_o)
  `ASSERT_IMPLY(a_axis_range, clk_i, rst_ni, 1'b1, ax_q != 2'd3)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_q && out_stall_i, out_q)
endmodule

// File: sv/ray_box_nearest_pick_core.sv
// Top level of the ray box pick core: APB registers, controller, datapath.
// Depends on rbp_pkg, rbp_ctrl and rbp_datapath.
//
//  channel | direction | handshake               | word
//  in      | input     | in_valid_i / in_stall_o | cmd, slot, p, q
//  out     | output    | out_valid_o/out_stall_i | hit, slot, distance
//  cfg     | input     | APB psel/penable        | box_count, epsilon
//
// Loads can follow back to back. A query reads, sets up and checks each axis of each box in
// turn; a dividing axis adds two 50-step divisions on one shared divider, a parallel axis
// skips them, and a box stops at its first rejecting axis. With no box in use, the result
// is valid in the cycle after the query is accepted. Reset is asynchronous and clears
// control and registers; tables are undefined until loaded. Input is stalled while a query
// runs or a result waits; the result holds while stalled.
module ray_box_nearest_pick_core (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic cmd_i,
  input  logic [3:0] box_slot_i,
  input  logic signed [31:0] p_x_i, p_y_i, p_z_i, q_x_i, q_y_i, q_z_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic hit_o,
  output logic [3:0] hit_slot_o,
  output logic [30:0] hit_distance_o
);
  logic [4:0] count_q;
  logic [15:0] eps_q;
  rbp_pkg::rbp_cmd_t cmd;
  rbp_pkg::rbp_stat_t stat;

  assign pready = 1'b1;

  // Write configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      eps_q <= 16'd1;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (paddr[2])
        rbp_pkg::RegBoxCount: count_q <= pwdata[4:0];
        default: eps_q <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rbp_pkg::RegBoxCount: prdata = {27'd0, count_q};
      default: prdata = {16'd0, eps_q};
    endcase
  end

  rbp_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .cmd_i(cmd_i), .box_slot_i(box_slot_i), .count_i(count_q),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .cmd_o(cmd), .stat_i(stat)
  );

  rbp_datapath u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .stat_o(stat), .eps_i(eps_q),
    .p_x_i(p_x_i), .p_y_i(p_y_i), .p_z_i(p_z_i),
    .q_x_i(q_x_i), .q_y_i(q_y_i), .q_z_i(q_z_i),
    .hit_o(hit_o), .hit_slot_o(hit_slot_o), .hit_distance_o(hit_distance_o)
  );
endmodule

// File: sim/ray_box_nearest_pick_core_tb.sv
// Testbench for ray_box_nearest_pick_core: loads boxes, fires query rays, checks picks.
// Depends on rbp_pkg and the core; predicts each pick with a slab test of its own.
`timescale 1ns / 1ps

module ray_box_nearest_pick_core_tb;

  typedef struct packed {
    logic [0:0] cmd;
    logic [3:0] slot;
    logic signed [31:0] px, py, pz, qx, qy, qz;
  } ray_word_t;

  typedef struct packed {
    logic hit;
    logic [3:0] slot;
    logic [30:0] distance;
  } pick_word_t;

  localparam int WatchdogLimit = 40000;
  localparam int DrainCycles = 2500;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  ray_word_t in_word = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o;
  logic [3:0] hit_slot_o;
  logic [30:0] hit_distance_o;

  ray_box_nearest_pick_core u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o,
    .cmd_i(in_word.cmd[0]), .box_slot_i(in_word.slot),
    .p_x_i(in_word.px), .p_y_i(in_word.py), .p_z_i(in_word.pz),
    .q_x_i(in_word.qx), .q_y_i(in_word.qy), .q_z_i(in_word.qz),
    .out_valid_o, .out_stall_i, .hit_o, .hit_slot_o, .hit_distance_o
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  longint box_cen[rbp_pkg::MaxBoxes][3];
  longint box_half[rbp_pkg::MaxBoxes][3];
  int unsigned pred_count = 0;
  int unsigned pred_eps = 1;

  ray_word_t pending_words[$];
  pick_word_t expected_picks[$];
  bit sender_hold = 1'b0;
  bit idle_on = 1'b1;
  bit failed = 1'b0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // Append one word to the send queue.
  task automatic enqueue_word(ray_word_t w);
    pending_words = {pending_words, w};
  endtask

  // Slab test of one box; returns hit and entry distance.
  function automatic bit slab_pass(ray_word_t r, int b, output longint t_entry);
    longint org[3], dir[3];
    longint t_lo, t_hi, lo, hi, mag, t0, t1, tmp;
    org = '{r.px, r.py, r.pz};
    dir = '{r.qx, r.qy, r.qz};
    t_lo = 0;
    t_hi = 64'sh7FFF_FFFF_FFFF_FFFF;
    t_entry = 0;
    for (int a = 0; a < 3; a++) begin
      lo = box_cen[b][a] - box_half[b][a];
      hi = box_cen[b][a] + box_half[b][a];
      mag = dir[a] < 0 ? -dir[a] : dir[a];
      if (dir[a] == 0 || mag < longint'(pred_eps)) begin
        if (org[a] < lo || org[a] > hi) return 1'b0;
        continue;
      end
      t0 = ((lo - org[a]) * 65536) / dir[a];
      t1 = ((hi - org[a]) * 65536) / dir[a];
      if (t0 > t1) begin
        tmp = t0; t0 = t1; t1 = tmp;
      end
      if (t0 > t_lo) t_lo = t0;
      if (t1 < t_hi) t_hi = t1;
      if (t_lo > t_hi) return 1'b0;
    end
    t_entry = t_lo;
    return t_hi >= 0;
  endfunction

  // Apply one accepted word to the predictor; queue the pick a query yields.
  task automatic predict_pick(ray_word_t r);
    pick_word_t p;
    longint t, best_t;
    int n;
    bit found;
    if (r.cmd == rbp_pkg::CmdLoad) begin
      box_cen[r.slot] = '{r.px, r.py, r.pz};
      box_half[r.slot] = '{r.qx, r.qy, r.qz};
      return;
    end
    n = pred_count > rbp_pkg::MaxBoxes ? rbp_pkg::MaxBoxes : pred_count;
    found = 1'b0;
    best_t = 0;
    p = '{hit: 1'b0, slot: '0, distance: rbp_pkg::DistSat};
    for (int i = 0; i < n; i++) begin
      if (slab_pass(r, i, t) && (!found || t < best_t)) begin
        found = 1'b1;
        best_t = t;
        p.slot = 4'(i);
      end
    end
    if (found) begin
      p.hit = 1'b1;
      p.distance = best_t > longint'(rbp_pkg::DistSat) ? rbp_pkg::DistSat : best_t[30:0];
    end
    expected_picks = {expected_picks, p};
  endtask

  // Driver: advance on acceptance, idle at random, stall the output at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_pick(in_word);
        if (pending_words.size() > 0 && !sender_hold &&
            !(idle_on && $urandom_range(99) < 37)) begin
          in_word <= pending_words.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i && pending_words.size() > 0 && !sender_hold &&
                   !(idle_on && $urandom_range(99) < 37)) begin
        in_word <= pending_words.pop_front();
        in_valid_i <= 1'b1;
      end
      out_stall_i <= idle_on && $urandom_range(99) < 37;
    end
  end

  // Monitor: compare each pick with the oldest expectation
  always @(posedge clk_i) begin
    pick_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_picks.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected pick word hit=%0d", hit_o);
      end else begin
        want = expected_picks.pop_front();
        if (hit_o !== want.hit || hit_slot_o !== want.slot ||
            hit_distance_o !== want.distance) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("pick mismatch: want hit=%0d slot=%0d dist=%h, got %0d %0d %h",
                     want.hit, want.slot, want.distance, hit_o, hit_slot_o, hit_distance_o);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [0:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == rbp_pkg::RegBoxCount) pred_count = val[4:0];
    else if (idx == rbp_pkg::RegEpsilon) pred_eps = val[15:0];
  endtask

  task automatic wait_idle();
    while (pending_words.size() > 0 || in_valid_i || expected_picks.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  function automatic ray_word_t load_word(int s, bit wild);
    ray_word_t w;
    w.cmd = rbp_pkg::CmdLoad;
    w.slot = 4'(s);
    if (wild) begin
      w.px = $urandom; w.py = $urandom; w.pz = $urandom;
      w.qx = $urandom; w.qy = $urandom; w.qz = $urandom;
    end else begin
      w.px = rand_coord(20 << 16); w.py = rand_coord(20 << 16);
      w.pz = rand_coord(20 << 16);
      w.qx = $urandom_range(8 << 16); w.qy = $urandom_range(8 << 16);
      w.qz = $urandom_range(8 << 16);
    end
    return w;
  endfunction

  function automatic ray_word_t query_word(bit wild);
    ray_word_t w;
    w = '0;
    w.cmd = rbp_pkg::CmdQuery;
    w.slot = 4'($urandom);
    if (wild) begin
      w.px = $urandom; w.py = $urandom; w.pz = $urandom;
      w.qx = $urandom; w.qy = $urandom; w.qz = $urandom;
    end else begin
      w.px = rand_coord(40 << 16); w.py = rand_coord(40 << 16);
      w.pz = rand_coord(40 << 16);
      w.qx = rand_coord(2 << 16); w.qy = rand_coord(2 << 16);
      w.qz = rand_coord(2 << 16);
      // sometimes make an axis exactly or nearly parallel
      if ($urandom_range(3) == 0) w.qy = $urandom_range(3) == 0 ? 0 : rand_coord(4);
    end
    return w;
  endfunction

  initial begin
    ray_word_t w;
    ray_word_t v;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: fill every slot, then edge queries
    reg_write(rbp_pkg::RegBoxCount, 0);
    reg_write(rbp_pkg::RegEpsilon, 0);
    for (int s = 0; s < rbp_pkg::MaxBoxes; s++) enqueue_word(load_word(s, 1'b0));
    w = query_word(1'b0);
    enqueue_word(w);                   // no boxes in use
    wait_idle();
    reg_write(rbp_pkg::RegBoxCount, 31);   // clamps to table size
    w = '0; w.cmd = rbp_pkg::CmdQuery; w.slot = 4'hF;
    enqueue_word(w);                   // zero direction, zero epsilon
    w = '{rbp_pkg::CmdQuery, 4'h0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
          32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001};
    enqueue_word(w);
    w = '{rbp_pkg::CmdQuery, 4'h0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
          32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF};
    enqueue_word(w);
    // identical boxes in slots 2 and 5 test the tie rule
    w = load_word(2, 1'b0);
    enqueue_word(w);
    w.slot = 5;
    enqueue_word(w);
    v = '{rbp_pkg::CmdQuery, 4'h0, w.px - (100 << 16), w.py, w.pz,
          32'sh0001_0000, 32'sh0, 32'sh0};
    enqueue_word(v);
    enqueue_word(load_word(7, 1'b1));   // wrapped extents
    enqueue_word(query_word(1'b1));
    // Pause until all picks drain once most words are out
    while (pending_words.size() > 2) @(posedge clk_i);
    sender_hold = 1'b1;
    while (expected_picks.size() > 0 || in_valid_i) @(posedge clk_i);
    sender_hold = 1'b0;
    wait_idle();

    // Random phases with changing settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin reg_write(rbp_pkg::RegEpsilon, 16'hFFFF);
                 reg_write(rbp_pkg::RegBoxCount, 16); end
        1: begin reg_write(rbp_pkg::RegEpsilon, 1); reg_write(rbp_pkg::RegBoxCount, 1); end
        2: begin reg_write(rbp_pkg::RegEpsilon, $urandom_range(65535));
                 reg_write(rbp_pkg::RegBoxCount, $urandom_range(2, 16)); end
        3: begin reg_write(rbp_pkg::RegEpsilon, 0); reg_write(rbp_pkg::RegBoxCount, 4); end
        default: begin reg_write(rbp_pkg::RegEpsilon, 16'h8000);
                       reg_write(rbp_pkg::RegBoxCount, 17); end
      endcase
      idle_on = ph != 2;
      for (int k = 0; k < 24; k++) begin
        if ($urandom_range(3) == 0)
          enqueue_word(load_word($urandom_range(15), $urandom_range(5) == 0));
        else
          enqueue_word(query_word($urandom_range(7) == 0));
      end
      wait_idle();
    end

    if (!failed && expected_picks.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
